@@ src/sd64_pkg.sv @@
`timescale 1ns / 1ps

package sd64_pkg;

  // Width of the operand and result fields at the block's ports.
  localparam int unsigned XLEN = 64;

  // Default number of significant operand bits (range 8 to 64).
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Per-item side information that travels down the pipeline with the data.
  typedef struct packed {
    logic nneg;  // dividend was negative
    logic dneg;  // divisor was negative
    logic dz;    // divisor was zero
  } flags_t;

endpackage

@@ src/sd64_if.sv @@
`timescale 1ns / 1ps

// Operand channel: one dividend and one divisor per transfer.
interface sd64_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sd64_pkg::XLEN-1:0]   dividend;
  logic signed [sd64_pkg::XLEN-1:0]   divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

// Result channel: quotient, remainder and zero-divisor flag per transfer.
interface sd64_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sd64_pkg::XLEN-1:0]   quotient;
  logic signed [sd64_pkg::XLEN-1:0]   remainder;
  logic                               divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink (input valid, input quotient, input remainder,
                input divide_by_zero, output ready);
endinterface

@@ src/sd64_prep.sv @@
`timescale 1ns / 1ps

// Input stage: takes the operands, forms their magnitudes, sign flags and zero-divisor flag.
module sd64_prep #(
  parameter int unsigned DATA_WIDTH = sd64_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sd64_in_if.sink                in_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [DATA_WIDTH-1:0]  numq_o,
  output logic [DATA_WIDTH-1:0]  den_o,
  output sd64_pkg::flags_t       flags_o
);

  logic                  valid_q;
  logic                  load;
  logic [DATA_WIDTH-1:0] num_w;
  logic [DATA_WIDTH-1:0] den_w;
  logic [DATA_WIDTH-1:0] num_d, num_q;
  logic [DATA_WIDTH-1:0] den_d, den_q;
  sd64_pkg::flags_t      flags_d, flags_q;

  // The stage takes a transfer when it is empty or its content moves on.
  assign load       = !valid_q || ready_i;
  assign in_i.ready = load;

  // Only the low DATA_WIDTH bits count; the top one of them is the sign.
  assign num_w = in_i.dividend[DATA_WIDTH-1:0];
  assign den_w = in_i.divisor[DATA_WIDTH-1:0];

  // Magnitudes in two's complement; the most negative value maps onto itself,
  // which read unsigned is the correct magnitude.
  always_comb begin
    flags_d.nneg = num_w[DATA_WIDTH-1];
    flags_d.dneg = den_w[DATA_WIDTH-1];
    flags_d.dz   = (den_w == '0);
    num_d        = flags_d.nneg ? ({DATA_WIDTH{1'b0}} - num_w) : num_w;
    den_d        = flags_d.dneg ? ({DATA_WIDTH{1'b0}} - den_w) : den_w;
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_i.valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load && in_i.valid) begin
      num_q   <= num_d;
      den_q   <= den_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign numq_o  = num_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

@@ src/sd64_step.sv @@
`timescale 1ns / 1ps

// One restoring shift-subtract step as a pipeline stage.
// numq holds the dividend bits not yet used at the top and the quotient
// bits found so far at the bottom.
module sd64_step #(
  parameter int unsigned DATA_WIDTH = sd64_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [DATA_WIDTH-1:0]  rem_i,
  input  logic [DATA_WIDTH-1:0]  numq_i,
  input  logic [DATA_WIDTH-1:0]  den_i,
  input  sd64_pkg::flags_t       flags_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [DATA_WIDTH-1:0]  rem_o,
  output logic [DATA_WIDTH-1:0]  numq_o,
  output logic [DATA_WIDTH-1:0]  den_o,
  output sd64_pkg::flags_t       flags_o
);

  logic                  valid_q;
  logic                  load;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fit;
  logic [DATA_WIDTH-1:0] rem_d, rem_q;
  logic [DATA_WIDTH-1:0] numq_d, numq_q;
  logic [DATA_WIDTH-1:0] den_q;
  sd64_pkg::flags_t      flags_q;

  assign load    = !valid_q || ready_i;
  assign ready_o = load;

  // Bring down the next dividend bit and try to subtract the divisor.
  // The remainder stays below the divisor, so the shifted value fits.
  always_comb begin
    trial  = {rem_i, numq_i[DATA_WIDTH-1]};
    diff   = trial - {1'b0, den_i};
    fit    = !diff[DATA_WIDTH];
    rem_d  = fit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    numq_d = {numq_i[DATA_WIDTH-2:0], fit};
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      rem_q   <= rem_d;
      numq_q  <= numq_d;
      den_q   <= den_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign numq_o  = numq_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

@@ src/sd64_post.sv @@
`timescale 1ns / 1ps

// Output stage: restores the signs, handles a zero divisor, sign-extends to
// the port width and holds the result until the receiver takes it.
module sd64_post #(
  parameter int unsigned DATA_WIDTH = sd64_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [DATA_WIDTH-1:0]  rem_i,
  input  logic [DATA_WIDTH-1:0]  numq_i,
  input  sd64_pkg::flags_t       flags_i,
  sd64_out_if.source             out_o
);

  localparam int unsigned XW = sd64_pkg::XLEN;

  logic                         valid_q;
  logic                         load;
  logic signed [DATA_WIDTH-1:0] quo_w;
  logic signed [DATA_WIDTH-1:0] rem_w;
  logic signed [XW-1:0]         quo_d, quo_q;
  logic signed [XW-1:0]         rem_d, rem_q;
  logic                         dz_q;

  assign load    = !valid_q || out_o.ready;
  assign ready_o = load;

  // Quotient is negative when exactly one operand was; the remainder follows
  // the dividend. A zero divisor forces both to zero.
  always_comb begin
    if (flags_i.dz) begin
      quo_w = '0;
      rem_w = '0;
    end else begin
      quo_w = (flags_i.nneg ^ flags_i.dneg) ? ({DATA_WIDTH{1'b0}} - numq_i) : numq_i;
      rem_w = flags_i.nneg ? ({DATA_WIDTH{1'b0}} - rem_i) : rem_i;
    end
    quo_d = XW'(quo_w);
    rem_d = XW'(rem_w);
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      dz_q  <= flags_i.dz;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.quotient       = quo_q;
  assign out_o.remainder      = rem_q;
  assign out_o.divide_by_zero = dz_q;

endmodule

@@ src/signed_divider_64.sv @@
`timescale 1ns / 1ps

// Signed integer divider with a fully pipelined restoring datapath.
//
// Operands arrive on in_i (dividend, divisor) with a valid/ready transfer;
// results leave on out_o (quotient, remainder, divide_by_zero). The quotient
// is truncated toward zero, the remainder has the sign of the dividend, and
// the most negative dividend divided by minus one wraps to itself. A zero
// divisor gives zero results with divide_by_zero set. Only the low
// DATA_WIDTH operand bits are used; results are sign-extended to 64 bits.
//
// The pipeline has one input stage, one stage per quotient bit, each with one
// subtract and compare, and one output register. A new transfer is accepted
// every cycle unless a stalled receiver has filled every stage.
//
// Reset clears every valid bit, so the pipeline comes up empty. When the
// receiver stalls, the result waits in the output register and the stages
// behind it keep filling bubbles; in_i.ready drops only once every stage
// holds an item. Nothing is lost or repeated across a stall.
module signed_divider_64 #(
  parameter int unsigned DATA_WIDTH = sd64_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sd64_in_if.sink      in_i,
  sd64_out_if.source   out_o
);

  // Stage k feeds step k; entry DATA_WIDTH feeds the output stage.
  logic                  stg_valid [DATA_WIDTH+1];
  logic                  stg_ready [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] stg_rem   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] stg_numq  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] stg_den   [DATA_WIDTH+1];
  sd64_pkg::flags_t      stg_flags [DATA_WIDTH+1];

  // Operand magnitudes and signs.
  sd64_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .numq_o  (stg_numq[0]),
    .den_o   (stg_den[0]),
    .flags_o (stg_flags[0])
  );

  // The partial remainder starts at zero.
  assign stg_rem[0] = '0;

  // One stage per quotient bit, most significant first.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    sd64_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .rem_i   (stg_rem[k]),
      .numq_i  (stg_numq[k]),
      .den_i   (stg_den[k]),
      .flags_i (stg_flags[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .rem_o   (stg_rem[k+1]),
      .numq_o  (stg_numq[k+1]),
      .den_o   (stg_den[k+1]),
      .flags_o (stg_flags[k+1])
    );
  end

  // Sign fix-up and output register.
  sd64_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[DATA_WIDTH]),
    .ready_o (stg_ready[DATA_WIDTH]),
    .rem_i   (stg_rem[DATA_WIDTH]),
    .numq_i  (stg_numq[DATA_WIDTH]),
    .flags_i (stg_flags[DATA_WIDTH]),
    .out_o   (out_o)
  );

  // Back-pressure reaches the input only through a stalled output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled while the output is free");

  // After the last step the remainder magnitude is below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[DATA_WIDTH] && !stg_flags[DATA_WIDTH].dz) |->
      (stg_rem[DATA_WIDTH] < stg_den[DATA_WIDTH]))
    else $error("final remainder not below divisor");

  // A zero divisor yields zero results.
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.divide_by_zero) |->
      ((out_o.quotient == '0) && (out_o.remainder == '0)))
    else $error("zero divisor gave nonzero result");

endmodule

@@ tb/signed_divider_64_test.sv @@
`timescale 1ns / 1ps

module signed_divider_64_test;

  // Port width of the operand and result fields.
  localparam int unsigned XLEN    = sd64_pkg::XLEN;

  // Operand width that the block works at, and its pipeline depth.
  localparam int unsigned DW      = sd64_pkg::DATA_WIDTH_DEF;
  localparam int unsigned LATENCY = DW + 2;

  // The run ends in failure after this many cycles without any transfer.
  localparam int unsigned STALL_LIMIT = 4000;

  // Operand and result codes that need special handling.
  localparam logic [XLEN-1:0] MOST_NEG  = {1'b1, {(XLEN-1){1'b0}}};
  localparam logic [XLEN-1:0] MOST_POS  = {1'b0, {(XLEN-1){1'b1}}};
  localparam logic [XLEN-1:0] MINUS_ONE = {XLEN{1'b1}};
  localparam logic [XLEN-1:0] ZERO      = '0;

  // One division outcome, as the result channel carries it.
  typedef struct packed {
    logic signed [XLEN-1:0] quotient;
    logic signed [XLEN-1:0] remainder;
    logic                   divide_by_zero;
  } division_t;

  logic clk;
  logic rst_n;
  bit   steady;
  int   mismatch_count;
  int   quiet_cycles;

  // Outcomes owed by the block, oldest first.
  division_t owed_divisions[$];

  sd64_in_if  op_if ();
  sd64_out_if res_if ();

  signed_divider_64 dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_if),
    .out_o  (res_if)
  );

  // Clock with an 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bits of the word that the block treats as significant.
  function automatic logic [XLEN-1:0] width_mask();
    return (DW >= XLEN) ? {XLEN{1'b1}} : ((64'd1 << DW) - 64'd1);
  endfunction

  // Sign-extends a DW-bit value to the full port width.
  function automatic logic [XLEN-1:0] sign_extend(input logic [XLEN-1:0] v);
    logic [XLEN-1:0] m;
    m = width_mask();
    v = v & m;
    if (v[DW-1]) v = v | ~m;
    return v;
  endfunction

  // Absolute value of a DW-bit operand, with its sign.
  function automatic logic [XLEN-1:0] abs_value(input logic [XLEN-1:0] v,
                                                output logic neg);
    logic [XLEN-1:0] m;
    m = width_mask();
    v = v & m;
    neg = v[DW-1];
    if (neg) v = (-v) & m;
    return v;
  endfunction

  // Restoring shift-subtract division on magnitudes, signs fixed afterward.
  function automatic division_t divide_restoring(input logic [XLEN-1:0] num_in,
                                                 input logic [XLEN-1:0] den_in);
    division_t       r;
    logic            num_neg;
    logic            den_neg;
    logic [XLEN-1:0] num;
    logic [XLEN-1:0] den;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] rem;
    num = abs_value(num_in, num_neg);
    den = abs_value(den_in, den_neg);
    quo = '0;
    rem = '0;
    if (den == '0) begin
      r.quotient       = '0;
      r.remainder      = '0;
      r.divide_by_zero = 1'b1;
      return r;
    end
    for (int i = DW - 1; i >= 0; i--) begin
      rem = {rem[XLEN-2:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    if (num_neg != den_neg) quo = (-quo) & width_mask();
    if (num_neg) rem = (-rem) & width_mask();
    r.quotient       = sign_extend(quo);
    r.remainder      = sign_extend(rem);
    r.divide_by_zero = 1'b0;
    return r;
  endfunction

  // Operand with a spread of magnitudes, signs and corner values.
  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] v;
    int              s;
    v = {$urandom, $urandom};
    s = int'($urandom_range(20)) - 10;
    case ($urandom_range(7))
      0, 1, 2: ;
      3: v = v >> $urandom_range(XLEN - 1);
      4: v = -(v >> $urandom_range(XLEN - 1));
      5: begin
        v = 64'd1 << $urandom_range(XLEN - 1);
        if ($urandom_range(1)) v = -v;
      end
      6: v = 64'(s);
      default: begin
        case ($urandom_range(3))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MINUS_ONE;
          default: v = ZERO;
        endcase
      end
    endcase
    return v;
  endfunction

  // Sends one operand pair and records the outcome it owes.
  task automatic send_division(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 24) begin
      op_if.valid = 1'b0;
      @(negedge clk);
    end
    op_if.valid    = 1'b1;
    op_if.dividend = a;
    op_if.divisor  = b;
    @(posedge clk);
    while (!op_if.ready) @(posedge clk);
    owed_divisions.push_back(divide_restoring(a, b));
  endtask

  // Lowers valid once the last transfer of a phase has gone.
  task automatic release_operands();
    @(negedge clk);
    op_if.valid = 1'b0;
  endtask

  // Extremes of both operands, zero divisors and the wrapping case.
  task automatic test_corners();
    send_division(ZERO, 64'd1);
    send_division(64'd1, 64'd1);
    send_division(MINUS_ONE, 64'd1);
    send_division(MOST_POS, 64'd1);
    send_division(MOST_NEG, 64'd1);
    send_division(MOST_NEG, MINUS_ONE);
    send_division(MOST_NEG, MOST_NEG);
    send_division(MOST_POS, MOST_POS);
    send_division(MOST_POS, MOST_NEG);
    send_division(MOST_NEG, MOST_POS);
    send_division(MOST_POS, MINUS_ONE);
    send_division(MINUS_ONE, MOST_NEG);
    send_division(64'd1, MOST_POS);
    send_division(MOST_NEG, 64'd2);
    send_division(64'd7, 64'd2);
    send_division(-64'd7, 64'd2);
    send_division(64'd7, -64'd2);
    send_division(-64'd7, -64'd2);
    send_division(ZERO, ZERO);
    send_division(64'd5, ZERO);
    send_division(MOST_NEG, ZERO);
    send_division(MOST_POS, ZERO);
    send_division(MINUS_ONE, ZERO);
    send_division(64'hA5A5_5A5A_F0F0_0F0F, 64'h5A5A_A5A5_0F0F_F0F0);
    release_operands();
  endtask

  // The sender holds off until the pipeline has fully drained, twice.
  task automatic test_drain_pause();
    for (int phase = 0; phase < 2; phase++) begin
      for (int n = 0; n < 40; n++) send_division(pick_operand(), pick_operand());
      release_operands();
      while (owed_divisions.size() != 0) @(posedge clk);
    end
  endtask

  // A long stream with both sides always willing.
  task automatic test_steady_stream();
    steady = 1'b1;
    for (int n = 0; n < 250; n++) send_division(pick_operand(), pick_operand());
    release_operands();
    steady = 1'b0;
  endtask

  // Random operand pairs with occasional zero divisors and wrap cases.
  task automatic test_random_mix();
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    for (int n = 0; n < 1100; n++) begin
      a = pick_operand();
      b = pick_operand();
      if ($urandom_range(99) < 3) b = ZERO;
      else if ($urandom_range(99) < 1) begin
        a = MOST_NEG;
        b = MINUS_ONE;
      end
      send_division(a, b);
    end
    release_operands();
  endtask

  // The result side stalls at random except during steady stretches.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = steady || ($urandom_range(99) >= 24);
    end
  end

  // Compares each result transfer with the oldest owed outcome.
  always @(posedge clk) begin
    division_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (owed_divisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: q=%h r=%h dz=%b", res_if.quotient,
                   res_if.remainder, res_if.divide_by_zero);
      end else begin
        want = owed_divisions.pop_front();
        if (res_if.quotient !== want.quotient || res_if.remainder !== want.remainder ||
            res_if.divide_by_zero !== want.divide_by_zero) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected q=%h r=%h dz=%b, got q=%h r=%h dz=%b",
                     want.quotient, want.remainder, want.divide_by_zero,
                     res_if.quotient, res_if.remainder, res_if.divide_by_zero);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Reset, the test sequence, and the final verdict.
  initial begin
    rst_n          = 1'b0;
    steady         = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    op_if.valid    = 1'b0;
    op_if.dividend = '0;
    op_if.divisor  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corners();
    test_drain_pause();
    test_steady_stream();
    test_random_mix();

    while (owed_divisions.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && owed_divisions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
